@@ rtl/urf_pkg.sv @@
// Shared types, constants and helper functions for the unique row filter.
// Every other file in rtl imports this package.
package urf_pkg;

	localparam int MAX_ROWS  = 64;
	localparam int MAX_COLS  = 16;
	localparam int ELEM_W    = 64;
	localparam int COL_W     = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
	localparam int ROW_W     = $clog2(MAX_ROWS);
	localparam int CNT_W     = $clog2(MAX_ROWS + 1);
	localparam int MEM_AW    = ROW_W + COL_W;
	localparam int MEM_DEPTH = MAX_ROWS * (2 ** COL_W);
	localparam int CMP_W     = 11;

	localparam int OP_W    = 2;
	localparam int RROW_W  = 6;
	localparam int RCOL_W  = 4;
	localparam int IDX_W   = 6;
	localparam int UCNT_W  = 7;
	localparam int LEN_W   = 5;
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;
	localparam int REG_W   = 1;

	localparam logic [REG_W-1:0] REG_ROW_LENGTH   = 1'b0;
	localparam logic [LEN_W-1:0] ROW_LENGTH_RESET = 5'd1;

	typedef enum logic [OP_W-1:0] {
		OP_PUSH  = 2'd0,
		OP_READ  = 2'd1,
		OP_CLEAR = 2'd2
	} op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_WALK,
		ST_COPY,
		ST_EMIT_READ,
		ST_EMIT_DUP,
		ST_EMIT_NEW,
		ST_EMIT_FULL
	} state_t;

	typedef enum logic [1:0] {
		RES_READ,
		RES_DUP,
		RES_NEW,
		RES_FULL
	} res_t;

	typedef struct packed {
		logic take;
		logic walk;
		logic copy;
		logic load;
		res_t res;
	} cmd_t;

	typedef struct packed {
		logic walk_busy;
		logic last;
		logic found;
		logic room;
		logic copy_last;
		logic out_free;
	} status_t;

	// Effective row length: zero counts as one, values above the column count saturate.
	function automatic logic [LEN_W-1:0] eff_len(input logic [LEN_W-1:0] rl);
		logic [LEN_W-1:0] r;
		r = rl;
		if (rl == '0) begin
			r = LEN_W'(1);
		end else if (CMP_W'(rl) > CMP_W'(MAX_COLS)) begin
			r = LEN_W'(MAX_COLS);
		end
		return r;
	endfunction

endpackage

@@ rtl/urf_ctrl.sv @@
// Controller state machine of the unique row filter.
// Depends on urf_pkg; drives commands into urf_datapath and reads its status.
module urf_ctrl (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  logic [urf_pkg::OP_W-1:0]      in_op,
	input  urf_pkg::status_t              status,
	output logic                          in_stall,
	output urf_pkg::cmd_t                 cmd
);
	import urf_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '{take: 1'b0, walk: 1'b0, copy: 1'b0, load: 1'b0, res: RES_READ};
		in_stall = 1'b1;
		case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				cmd.take = in_valid;
				if (in_valid) begin
					if (in_op == OP_PUSH) begin
						state_d = ST_WALK;
					end else if (in_op == OP_READ) begin
						state_d = ST_EMIT_READ;
					end
				end
			end
			ST_WALK: begin
				cmd.walk = 1'b1;
				if (!status.walk_busy) begin
					if (!status.last) begin
						state_d = ST_IDLE;
					end else if (status.found) begin
						state_d = ST_EMIT_DUP;
					end else if (status.room) begin
						state_d = ST_COPY;
					end else begin
						state_d = ST_EMIT_FULL;
					end
				end
			end
			ST_COPY: begin
				cmd.copy = 1'b1;
				if (status.copy_last) begin
					state_d = ST_EMIT_NEW;
				end
			end
			ST_EMIT_READ, ST_EMIT_DUP, ST_EMIT_NEW, ST_EMIT_FULL: begin
				case (state_q)
					ST_EMIT_READ: cmd.res = RES_READ;
					ST_EMIT_DUP:  cmd.res = RES_DUP;
					ST_EMIT_NEW:  cmd.res = RES_NEW;
					default:      cmd.res = RES_FULL;
				endcase
				if (status.out_free) begin
					cmd.load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

@@ rtl/urf_datapath.sv @@
// Datapath of the unique row filter: row store memory, row buffer, match bits,
// counters and the output register. Depends on urf_pkg; controlled by urf_ctrl.
module urf_datapath (
	input  logic                            clk,
	input  logic                            arst_n,
	input  urf_pkg::cmd_t                   cmd,
	output urf_pkg::status_t                status,
	input  logic [urf_pkg::OP_W-1:0]        in_op,
	input  logic [urf_pkg::ELEM_W-1:0]      in_elem,
	input  logic [urf_pkg::RROW_W-1:0]      in_read_row,
	input  logic [urf_pkg::RCOL_W-1:0]      in_read_col,
	input  logic [urf_pkg::LEN_W-1:0]       len,
	input  logic                            out_stall,
	output logic                            out_valid,
	output logic                            out_kind,
	output logic                            out_is_new,
	output logic [urf_pkg::IDX_W-1:0]       out_match_index,
	output logic [urf_pkg::UCNT_W-1:0]      out_unique_count,
	output logic                            out_any_duplicate,
	output logic                            out_table_full,
	output logic [urf_pkg::ELEM_W-1:0]      out_read_data
);
	import urf_pkg::*;

	logic [ELEM_W-1:0]   mem [MEM_DEPTH];
	logic [ELEM_W-1:0]   mem_rdata_q;
	logic [ELEM_W-1:0]   rowbuf_q [MAX_COLS];
	logic [ELEM_W-1:0]   elem_q;
	logic [COL_W-1:0]    col_q;
	logic [COL_W-1:0]    c_q;
	logic [COL_W-1:0]    cp_q;
	logic                last_q;
	logic [CNT_W-1:0]    cnt_q;
	logic                dup_q;
	logic [MAX_ROWS-1:0] match_q;
	logic [CNT_W-1:0]    s_q;
	logic                v_s1;
	logic [ROW_W-1:0]    slot_s1;
	logic                found_q;
	logic [ROW_W-1:0]    found_idx_q;
	logic                rd_ok_q;

	logic                out_valid_q;
	logic                out_kind_q;
	logic                out_is_new_q;
	logic [IDX_W-1:0]    out_idx_q;
	logic [UCNT_W-1:0]   out_cnt_q;
	logic                out_dup_q;
	logic                out_full_q;
	logic [ELEM_W-1:0]   out_data_q;

	logic                take_push;
	logic                take_read;
	logic                take_clear;
	logic                walk_go;
	logic                last_now;
	logic                new_bit;
	logic                out_free;
	logic                rd_en;
	logic [MEM_AW-1:0]   rd_addr;
	logic [MEM_AW-1:0]   wr_addr;
	logic [CNT_W-1:0]    cnt_inc;

	assign take_push  = cmd.take && (in_op == OP_PUSH);
	assign take_read  = cmd.take && (in_op == OP_READ);
	assign take_clear = cmd.take && (in_op == OP_CLEAR);
	assign walk_go    = cmd.walk && (s_q < cnt_q);
	assign last_now   = (CMP_W'(col_q) + CMP_W'(1)) >= CMP_W'(len);
	assign new_bit    = (mem_rdata_q == elem_q) && ((c_q == '0) || match_q[slot_s1]);
	assign out_free   = !out_valid_q || !out_stall;
	assign cnt_inc    = cnt_q + CNT_W'(1);

	assign rd_en   = walk_go || take_read;
	assign rd_addr = walk_go ? {s_q[ROW_W-1:0], c_q}
	                         : {ROW_W'(in_read_row), COL_W'(in_read_col)};
	assign wr_addr = {cnt_q[ROW_W-1:0], cp_q};

	always_ff @(posedge clk) begin
		if (cmd.copy) begin
			mem[wr_addr] <= rowbuf_q[cp_q];
		end
		if (rd_en) begin
			mem_rdata_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (take_push) begin
			rowbuf_q[col_q] <= in_elem;
			elem_q          <= in_elem;
			c_q             <= col_q;
		end
		if (take_read) begin
			rd_ok_q <= (CMP_W'(in_read_row) < CMP_W'(cnt_q))
			        && (CMP_W'(in_read_col) < CMP_W'(MAX_COLS));
		end
		if (walk_go) begin
			slot_s1 <= s_q[ROW_W-1:0];
		end
		if (v_s1 && last_q && new_bit && !found_q) begin
			found_idx_q <= slot_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q       <= '0;
			cp_q        <= '0;
			last_q      <= 1'b0;
			cnt_q       <= '0;
			dup_q       <= 1'b0;
			match_q     <= '0;
			s_q         <= '0;
			v_s1        <= 1'b0;
			found_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			v_s1 <= walk_go;
			if (walk_go) begin
				s_q <= s_q + CNT_W'(1);
			end
			if (v_s1) begin
				match_q[slot_s1] <= new_bit;
				if (last_q && new_bit) begin
					found_q <= 1'b1;
				end
			end
			if (cmd.copy) begin
				cp_q <= cp_q + COL_W'(1);
			end
			if (take_push) begin
				last_q  <= last_now;
				col_q   <= last_now ? '0 : col_q + COL_W'(1);
				s_q     <= '0;
				found_q <= 1'b0;
				cp_q    <= '0;
			end
			if (take_clear) begin
				cnt_q   <= '0;
				col_q   <= '0;
				dup_q   <= 1'b0;
				match_q <= '0;
			end
			if (cmd.load) begin
				out_valid_q <= 1'b1;
				if (cmd.res == RES_NEW) begin
					cnt_q <= cnt_inc;
				end
				if (cmd.res == RES_DUP) begin
					dup_q <= 1'b1;
				end
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			out_kind_q   <= 1'b0;
			out_is_new_q <= 1'b0;
			out_idx_q    <= '0;
			out_cnt_q    <= UCNT_W'(cnt_q);
			out_dup_q    <= dup_q;
			out_full_q   <= 1'b0;
			out_data_q   <= '0;
			case (cmd.res)
				RES_READ: begin
					out_kind_q <= 1'b1;
					out_data_q <= rd_ok_q ? mem_rdata_q : '0;
				end
				RES_DUP: begin
					out_idx_q <= IDX_W'(found_idx_q);
					out_dup_q <= 1'b1;
				end
				RES_NEW: begin
					out_is_new_q <= 1'b1;
					out_idx_q    <= IDX_W'(cnt_q);
					out_cnt_q    <= UCNT_W'(cnt_inc);
				end
				default: begin
					out_is_new_q <= 1'b1;
					out_full_q   <= 1'b1;
				end
			endcase
		end
	end

	assign status = '{
		walk_busy: (s_q < cnt_q) || v_s1,
		last:      last_q,
		found:     found_q,
		room:      CMP_W'(cnt_q) < CMP_W'(MAX_ROWS),
		copy_last: (CMP_W'(cp_q) + CMP_W'(1)) >= CMP_W'(len),
		out_free:  out_free
	};

	assign out_valid         = out_valid_q;
	assign out_kind          = out_kind_q;
	assign out_is_new        = out_is_new_q;
	assign out_match_index   = out_idx_q;
	assign out_unique_count  = out_cnt_q;
	assign out_any_duplicate = out_dup_q;
	assign out_table_full    = out_full_q;
	assign out_read_data     = out_data_q;

endmodule

@@ rtl/unique_row_filter.sv @@
// Top level of the unique row filter: register port, controller and datapath.
// Depends on urf_pkg, urf_ctrl and urf_datapath.
//
//  Channel  Direction  Handshake           Payload
//  -------  ---------  ------------------  ---------------------------------------------
//  input    in         in_valid/in_stall   op, elem_value, read_row, read_col
//  output   out        out_valid/out_stall kind, is_new, match_index, unique_count,
//                                          any_duplicate, table_full, read_data
//  config   in         psel/penable/pready paddr, pwdata, pwrite, prdata
//
// One transaction at a time: a push walks the N stored distinct rows, each read once from
// the row store. A row that ends new is then written to the row store column by column,
// and a row end loads the output register. A read fetches its element from the row store
// and loads the output register; a clear does neither. Reset leaves the table empty with
// a row length of one. A stalled output register holds its transaction and the next input
// is still accepted; only the following result waits, with the input stalled.
module unique_row_filter (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [urf_pkg::PADDR_W-1:0]     paddr,
	input  logic [urf_pkg::PDATA_W-1:0]     pwdata,
	output logic [urf_pkg::PDATA_W-1:0]     prdata,
	output logic                            pready,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [urf_pkg::OP_W-1:0]        op,
	input  logic [urf_pkg::ELEM_W-1:0]      elem_value,
	input  logic [urf_pkg::RROW_W-1:0]      read_row,
	input  logic [urf_pkg::RCOL_W-1:0]      read_col,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic                            kind,
	output logic                            is_new,
	output logic [urf_pkg::IDX_W-1:0]       match_index,
	output logic [urf_pkg::UCNT_W-1:0]      unique_count,
	output logic                            any_duplicate,
	output logic                            table_full,
	output logic [urf_pkg::ELEM_W-1:0]      read_data
);
	import urf_pkg::*;

	logic [LEN_W-1:0] row_length_q;
	logic [REG_W-1:0] reg_idx;
	logic [LEN_W-1:0] len;
	cmd_t             cmd;
	status_t          status;

	assign pready  = 1'b1;
	assign reg_idx = paddr[PADDR_W-1:2];
	assign prdata  = (reg_idx == REG_ROW_LENGTH) ? PDATA_W'(row_length_q) : '0;
	assign len     = eff_len(row_length_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_length_q <= ROW_LENGTH_RESET;
		end else if (psel && penable && pwrite && pready && (reg_idx == REG_ROW_LENGTH)) begin
			row_length_q <= pwdata[LEN_W-1:0];
		end
	end

	urf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_op    (op),
		.status   (status),
		.in_stall (in_stall),
		.cmd      (cmd)
	);

	urf_datapath u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.cmd               (cmd),
		.status            (status),
		.in_op             (op),
		.in_elem           (elem_value),
		.in_read_row       (read_row),
		.in_read_col       (read_col),
		.len               (len),
		.out_stall         (out_stall),
		.out_valid         (out_valid),
		.out_kind          (kind),
		.out_is_new        (is_new),
		.out_match_index   (match_index),
		.out_unique_count  (unique_count),
		.out_any_duplicate (any_duplicate),
		.out_table_full    (table_full),
		.out_read_data     (read_data)
	);

endmodule

@@ rtl/urf_checker.sv @@
// Port-level assertions for the unique row filter, bound to its top level.
// Depends on urf_pkg and unique_row_filter.
module urf_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            out_valid,
	input logic                            out_stall,
	input logic                            kind,
	input logic                            is_new,
	input logic [urf_pkg::IDX_W-1:0]       match_index,
	input logic [urf_pkg::UCNT_W-1:0]      unique_count,
	input logic                            any_duplicate,
	input logic                            table_full,
	input logic [urf_pkg::ELEM_W-1:0]      read_data
);
	import urf_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(read_data)
			&& $stable(match_index) && $stable(unique_count))
		else $error("Stalled output transaction changed.");

	a_read_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind |-> !is_new && !table_full && (match_index == '0))
		else $error("Read transaction carries decision fields.");

	a_dup_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !kind && !is_new |-> any_duplicate && (read_data == '0))
		else $error("Duplicate decision without the sticky flag.");

	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && table_full |-> is_new && !kind && (unique_count == UCNT_W'(MAX_ROWS)))
		else $error("Full flag while the table is not full.");

	a_new_slot: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !kind && is_new && !table_full
			|-> unique_count == UCNT_W'(match_index) + UCNT_W'(1))
		else $error("New row slot does not match the distinct count.");

endmodule

bind unique_row_filter urf_checker u_urf_checker (.*);
